>>> sv/fpsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared types and constants for the free page stack allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

	localparam int ADDR_W            = 40;
	localparam int STATUS_W          = 2;
	localparam int CFG_IDX_W         = 1;
	localparam int DEF_STACK_DEPTH   = 32768;
	localparam int DEF_PAGE_SHIFT    = 12;

	typedef enum logic [0:0] {
		KIND_FREE  = 1'b0,
		KIND_ALLOC = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_ADDR = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REGION_START = 1'b0,
		REG_REGION_END   = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] address;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] page_address;
	} out_item_t;

	// stack commands from the control side
	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

	// stack fill flags back to the control side
	typedef struct packed {
		logic empty;
		logic full;
	} stk_flags_t;

endpackage : fpsa_pkg
`default_nettype wire

>>> sv/fpsa_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpsa_stack
// Page number stack: one synchronous memory plus a fill count. Push writes
// at the count, pop reads the top into a registered output.
// ----------------------------------------------------------------------------
module fpsa_stack
	import fpsa_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int PAGE_W      = ADDR_W - DEF_PAGE_SHIFT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stk_cmd_t          cmd,
	input  wire logic [PAGE_W-1:0] push_page,
	output      logic [PAGE_W-1:0] pop_page,
	output      stk_flags_t        flags
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	logic [PAGE_W-1:0] mem [STACK_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_dec;
	logic [IDX_W-1:0]  push_idx;
	logic [IDX_W-1:0]  top_idx;
	logic [PAGE_W-1:0] pop_page_q;

	assign count_dec   = count_q - 1'b1;
	assign push_idx    = count_q[IDX_W-1:0];
	assign top_idx     = count_dec[IDX_W-1:0];
	assign flags.empty = (count_q == '0);
	assign flags.full  = (count_q == CNT_W'(STACK_DEPTH));
	assign pop_page    = pop_page_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[push_idx] <= push_page;
		end
		if (cmd.pop) begin
			pop_page_q <= mem[top_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			count_q <= count_dec;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !flags.full)
		else $error("push into full stack");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !flags.empty)
		else $error("pop from empty stack");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop in one cycle");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> count_q == $past(count_q) + 1'b1)
		else $error("count did not advance on push");

endmodule : fpsa_stack
`default_nettype wire

>>> sv/free_page_stack_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// free_page_stack_allocator_unit
// Physical page allocator holding free page numbers on a LIFO stack.
//
// Request channel (in_valid / in_stall / in_item): kind selects free or
// allocate; address is the page byte address to free. Response channel
// (out_valid / out_stall / out_item): one beat per request with a status
// and, for a successful allocate, the page byte address.
// A free or a failed allocate answers in the cycle after the request beat
// (registered result). A successful allocate reads the stack memory into
// its pop register, then answers from the result register. A request is
// taken once the result register is free and no stack read is pending, so
// frees run one per cycle unless the response stalls. Reset empties the stack
// (fill count to zero) and clears both region registers, so every free is
// rejected until they are written. The user must write the region registers
// through cfg_we / cfg_index / cfg_data only while idle; the block does not
// enforce it. A stalled response holds its beat and back-pressures requests.
// ----------------------------------------------------------------------------
module free_page_stack_allocator_unit
	import fpsa_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int PAGE_SHIFT  = DEF_PAGE_SHIFT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire in_item_t             in_item,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      out_item_t            out_item
);

	localparam int PAGE_W = ADDR_W - PAGE_SHIFT;

	logic [ADDR_W-1:0] region_start_q;
	logic [ADDR_W-1:0] region_end_q;
	state_t            state_q;
	state_t            state_d;
	logic              out_valid_q;
	out_item_t         out_item_q;
	logic              out_free;
	logic              in_acc;
	logic              is_free;
	logic              addr_ok;
	logic              load_now;
	logic              load_read;
	status_t           now_status;
	stk_cmd_t          cmd;
	stk_flags_t        flags;
	logic [PAGE_W-1:0] pop_page;

	fpsa_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.PAGE_W      (PAGE_W)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push_page (in_item.address[ADDR_W-1:PAGE_SHIFT]),
		.pop_page  (pop_page),
		.flags     (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			region_end_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REGION_START: region_start_q <= cfg_data;
				REG_REGION_END:   region_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_free = (in_item.kind == KIND_FREE);
	assign addr_ok = (in_item.address[PAGE_SHIFT-1:0] == '0)
		&& (in_item.address >= region_start_q)
		&& (in_item.address < region_end_q);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		priority if (!is_free) begin
			now_status = ST_EMPTY;
		end else if (!addr_ok) begin
			now_status = ST_BAD_ADDR;
		end else if (flags.full) begin
			now_status = ST_FULL;
		end else begin
			now_status = ST_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (cmd.pop) begin
				state_d = S_READ;
			end
			S_READ: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall  = (state_q != S_IDLE) || !out_free;
		in_acc    = in_valid && !in_stall;
		cmd.push  = in_acc && is_free && addr_ok && !flags.full;
		cmd.pop   = in_acc && !is_free && !flags.empty;
		load_now  = in_acc && !cmd.pop;
		load_read = (state_q == S_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_now || load_read) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_read) begin
			out_item_q.status       <= ST_OK;
			out_item_q.page_address <= {pop_page, {PAGE_SHIFT{1'b0}}};
		end else if (load_now) begin
			out_item_q.status       <= now_status;
			out_item_q.page_address <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// pop data lands while the result register is empty
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !out_valid_q)
		else $error("result register busy during stack read");

	a_pop_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> (state_q == S_READ) && in_stall)
		else $error("pop not followed by read cycle");

	a_read_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> out_valid_q && (out_item_q.status == ST_OK))
		else $error("read cycle did not produce a result");

endmodule : free_page_stack_allocator_unit
`default_nettype wire
